@@ sv/cbt_pkg.sv @@
package cbt_pkg;

	// Field and bus widths, default node limit
	localparam int IN_W          = 7;
	localparam int S_TDATA_W     = 16;
	localparam int M_TDATA_W     = 8;
	localparam int MAX_NODES_DEF = 32;

	// Child field code for "no child"
	localparam logic [IN_W-1:0] CHILD_NONE = {IN_W{1'b1}};

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;           // input beat accepted
		logic scan_init;      // clear scan index and found flag
		logic scan_rd;        // read child table at scan index
		logic scan_cmp;       // check read entry, track root, advance index
		logic walk_root;      // start walk at root, clear queue
		logic push_l;         // push left child of current node
		logic push_r;         // push right child of current node
		logic pop_rd;         // read queue head, advance head
		logic pop_chk;        // read child table for popped node
		logic tree_clear;     // drop per-tree marks
		logic out_load;       // load result register
		logic res_complete;
		logic res_malformed;
	} cbt_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic bad;            // bad index or overflow seen during load
		logic scan_end;       // scan index is the last node
		logic scan_bad;       // table entry names a node beyond the count
		logic found;          // a node without parent was seen
		logic q_empty;        // queue head equals tail
		logic e_zero;         // popped entry is an empty slot
		logic walk_limit;     // visited as many nodes as the tree holds
		logic out_busy;       // result register full and stalled
	} cbt_sts_t;

endpackage

@@ sv/cbt_ram.sv @@
module cbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/cbt_ctrl.sv @@
module cbt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tlast,
	output logic              s_tready,
	input  cbt_pkg::cbt_sts_t sts,
	output cbt_pkg::cbt_cmd_t cmd
);
	import cbt_pkg::*;

	localparam logic [3:0] S_LOAD      = 4'd0;
	localparam logic [3:0] S_CHECK     = 4'd1;
	localparam logic [3:0] S_SCAN_RD   = 4'd2;
	localparam logic [3:0] S_SCAN_CMP  = 4'd3;
	localparam logic [3:0] S_ROOT      = 4'd4;
	localparam logic [3:0] S_PUSH_L    = 4'd5;
	localparam logic [3:0] S_PUSH_R    = 4'd6;
	localparam logic [3:0] S_POP_RD    = 4'd7;
	localparam logic [3:0] S_POP_CHK   = 4'd8;
	localparam logic [3:0] S_DRAIN_RD  = 4'd9;
	localparam logic [3:0] S_DRAIN_CHK = 4'd10;
	localparam logic [3:0] S_DONE      = 4'd11;

	logic [3:0] state_q, state_d;
	logic       res_complete_q, res_complete_d;
	logic       res_malformed_q, res_malformed_d;
	logic       accept;

	assign s_tready = (state_q == S_LOAD);
	assign accept   = s_tvalid && s_tready;

	// Next state, commands and verdict
	always_comb begin
		state_d         = state_q;
		res_complete_d  = res_complete_q;
		res_malformed_d = res_malformed_q;
		cmd             = '0;
		cmd.res_complete  = res_complete_q;
		cmd.res_malformed = res_malformed_q;
		unique case (state_q)
			S_LOAD: begin
				cmd.load = accept;
				if (accept && s_tlast) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.bad) begin
					res_complete_d  = 1'b0;
					res_malformed_d = 1'b1;
					state_d         = S_DONE;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_d     = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				cmd.scan_cmp = 1'b1;
				if (sts.scan_bad) begin
					res_complete_d  = 1'b0;
					res_malformed_d = 1'b1;
					state_d         = S_DONE;
				end else if (sts.scan_end) begin
					state_d = S_ROOT;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_ROOT: begin
				if (!sts.found) begin
					res_complete_d  = 1'b0;
					res_malformed_d = 1'b1;
					state_d         = S_DONE;
				end else begin
					cmd.walk_root = 1'b1;
					state_d       = S_PUSH_L;
				end
			end
			S_PUSH_L: begin
				cmd.push_l = 1'b1;
				state_d    = S_PUSH_R;
			end
			S_PUSH_R: begin
				cmd.push_r = 1'b1;
				state_d    = S_POP_RD;
			end
			S_POP_RD: begin
				cmd.pop_rd = 1'b1;
				state_d    = S_POP_CHK;
			end
			S_POP_CHK: begin
				if (sts.e_zero) begin
					state_d = S_DRAIN_RD;
				end else if (sts.walk_limit) begin
					// revisited nodes: the walk ran past the node count
					res_complete_d  = 1'b0;
					res_malformed_d = 1'b0;
					state_d         = S_DONE;
				end else begin
					cmd.pop_chk = 1'b1;
					state_d     = S_PUSH_L;
				end
			end
			S_DRAIN_RD: begin
				if (sts.q_empty) begin
					res_complete_d  = 1'b1;
					res_malformed_d = 1'b0;
					state_d         = S_DONE;
				end else begin
					cmd.pop_rd = 1'b1;
					state_d    = S_DRAIN_CHK;
				end
			end
			S_DRAIN_CHK: begin
				if (!sts.e_zero) begin
					res_complete_d  = 1'b0;
					res_malformed_d = 1'b0;
					state_d         = S_DONE;
				end else begin
					state_d = S_DRAIN_RD;
				end
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load   = 1'b1;
					cmd.tree_clear = 1'b1;
					state_d        = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Verdict held until the result register takes it
	always_ff @(posedge clk) begin
		res_complete_q  <= res_complete_d;
		res_malformed_q <= res_malformed_d;
	end

	a_last_starts_check: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast) |=> (state_q == S_CHECK))
		else $error("last beat did not start the check");

	a_done_returns_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !sts.out_busy) |=> (state_q == S_LOAD && s_tready))
		else $error("result hand-off did not reopen the input");

endmodule

@@ sv/cbt_dp.sv @@
module cbt_dp #(
	parameter int MAX_NODES = cbt_pkg::MAX_NODES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [cbt_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          m_tready,
	output logic                          m_tvalid,
	output logic [cbt_pkg::M_TDATA_W-1:0] m_tdata,
	input  cbt_pkg::cbt_cmd_t             cmd,
	output cbt_pkg::cbt_sts_t             sts
);
	import cbt_pkg::*;

	localparam int IW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;   // node index
	localparam int CW  = $clog2(MAX_NODES + 1);                      // child number / count
	localparam int QD  = 2 * MAX_NODES;                              // queue depth
	localparam int QAW = $clog2(QD);                                 // queue address
	localparam int QCW = $clog2(QD + 1);                             // queue position

	logic [IN_W-1:0]      l_raw, r_raw;
	logic                 l_none, r_none, l_ok, r_ok, l_bad, r_bad;
	logic [CW-1:0]        l_child, r_child;
	logic [IW-1:0]        l_idx, r_idx;

	logic [MAX_NODES-1:0] hp_q;
	logic [CW-1:0]        node_cnt_q;
	logic                 bad_q;
	logic                 cnt_room;

	logic [CW-1:0]        idx_q;
	logic [IW-1:0]        root_q;
	logic                 found_q;
	logic [CW-1:0]        real_q;
	logic [QCW-1:0]       head_q, tail_q;

	logic                 tbl_we, tbl_re;
	logic [IW-1:0]        tbl_raddr;
	logic [2*CW-1:0]      tbl_rdata;
	logic [CW-1:0]        tbl_l, tbl_r;

	logic                 q_we;
	logic [CW-1:0]        q_wdata, q_rdata;

	logic                 m_tvalid_q;
	logic                 res_complete_q, res_malformed_q;

	// Decode child fields
	assign l_raw   = s_tdata[IN_W-1:0];
	assign r_raw   = s_tdata[2*IN_W-1:IN_W];
	assign l_none  = (l_raw == CHILD_NONE);
	assign r_none  = (r_raw == CHILD_NONE);
	assign l_ok    = !l_raw[IN_W-1] && (l_raw != '0)
		&& (32'(l_raw[IN_W-2:0]) <= 32'(MAX_NODES));
	assign r_ok    = !r_raw[IN_W-1] && (r_raw != '0)
		&& (32'(r_raw[IN_W-2:0]) <= 32'(MAX_NODES));
	assign l_bad   = !l_none && !l_ok;
	assign r_bad   = !r_none && !r_ok;
	assign l_child = l_ok ? CW'(l_raw[IN_W-2:0]) : '0;
	assign r_child = r_ok ? CW'(r_raw[IN_W-2:0]) : '0;
	assign l_idx   = IW'(l_raw[IN_W-2:0] - (IN_W-1)'(1));
	assign r_idx   = IW'(r_raw[IN_W-2:0] - (IN_W-1)'(1));
	assign cnt_room = (node_cnt_q < CW'(MAX_NODES));

	// Per-tree marks: parent bits, node count, bad flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q       <= '0;
			node_cnt_q <= '0;
			bad_q      <= 1'b0;
		end else if (cmd.tree_clear) begin
			hp_q       <= '0;
			node_cnt_q <= '0;
			bad_q      <= 1'b0;
		end else if (cmd.load) begin
			if (l_ok) begin
				hp_q[l_idx] <= 1'b1;
			end
			if (r_ok) begin
				hp_q[r_idx] <= 1'b1;
			end
			if (cnt_room) begin
				node_cnt_q <= node_cnt_q + CW'(1);
			end
			if (l_bad || r_bad || !cnt_room) begin
				bad_q <= 1'b1;
			end
		end
	end

	// Child table: right child in the upper half, left child in the lower
	assign tbl_we = cmd.load && cnt_room;
	assign tbl_re = cmd.scan_rd || cmd.walk_root || cmd.pop_chk;
	assign tbl_l  = tbl_rdata[CW-1:0];
	assign tbl_r  = tbl_rdata[2*CW-1:CW];

	always_comb begin
		priority if (cmd.walk_root) begin
			tbl_raddr = root_q;
		end else if (cmd.pop_chk) begin
			tbl_raddr = IW'(q_rdata - CW'(1));
		end else begin
			tbl_raddr = idx_q[IW-1:0];
		end
	end

	cbt_ram #(
		.WIDTH (2 * CW),
		.DEPTH (MAX_NODES)
	) u_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (node_cnt_q[IW-1:0]),
		.wdata ({r_child, l_child}),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	// Scan: track highest node without parent
	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.scan_cmp) begin
			if (!hp_q[idx_q[IW-1:0]]) begin
				root_q  <= idx_q[IW-1:0];
				found_q <= 1'b1;
			end
			idx_q <= idx_q + CW'(1);
		end
	end

	// Walk counters: visited nodes, queue head and tail
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_q <= '0;
			head_q <= '0;
			tail_q <= '0;
		end else if (cmd.tree_clear) begin
			real_q <= '0;
		end else if (cmd.walk_root) begin
			real_q <= CW'(1);
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (cmd.pop_chk) begin
				real_q <= real_q + CW'(1);
			end
			if (q_we) begin
				tail_q <= tail_q + QCW'(1);
			end
			if (cmd.pop_rd) begin
				head_q <= head_q + QCW'(1);
			end
		end
	end

	// Walk queue
	assign q_we    = cmd.push_l || cmd.push_r;
	assign q_wdata = cmd.push_l ? tbl_l : tbl_r;

	cbt_ram #(
		.WIDTH (CW),
		.DEPTH (QD)
	) u_queue (
		.clk   (clk),
		.we    (q_we),
		.waddr (tail_q[QAW-1:0]),
		.wdata (q_wdata),
		.re    (cmd.pop_rd),
		.raddr (head_q[QAW-1:0]),
		.rdata (q_rdata)
	);

	// Result register: hold until the receiver takes the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_complete_q  <= cmd.res_complete;
			res_malformed_q <= cmd.res_malformed;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W-2){1'b0}}, res_malformed_q, res_complete_q};

	// Status
	always_comb begin
		sts            = '0;
		sts.bad        = bad_q;
		sts.scan_end   = ({1'b0, idx_q} + {{CW{1'b0}}, 1'b1}) == {1'b0, node_cnt_q};
		sts.scan_bad   = (tbl_l > node_cnt_q) || (tbl_r > node_cnt_q);
		sts.found      = found_q;
		sts.q_empty    = (head_q == tail_q);
		sts.e_zero     = (q_rdata == '0);
		sts.walk_limit = (real_q >= node_cnt_q);
		sts.out_busy   = m_tvalid_q && !m_tready;
	end

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(m_tvalid_q && !m_tready))
		else $error("result register loaded while still stalled");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_rd |-> (head_q != tail_q))
		else $error("queue popped while empty");

	a_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		real_q <= node_cnt_q)
		else $error("walk visited more nodes than the tree holds");

endmodule

@@ sv/complete_binary_tree_check.sv @@
// Complete binary tree check.
// Input stream (s_*): one beat per node, nodes in index order. s_tdata holds
// the left and right child as 1-based node numbers (7-bit signed, -1 for no
// child); s_tlast marks the final node of the tree and starts the check.
// Output stream (m_*): one beat per tree, bit 0 complete, bit 1 malformed.
// Node beats are taken one per cycle while s_tready is high. After the last
// node, the scan reads the child table entry by entry; then every visited
// node costs a table read, two queue writes and a queue read, in that order.
// A malformed tree (bad child index, overflow, no root) skips the walk.
// s_tready is low from the last node until the verdict enters the output
// register. The verdict waits there while the receiver stalls, and the next
// tree loads meanwhile; a second verdict waits until the first is taken.
// Reset clears the control state and the per-tree parent marks; the child
// table and queue hold no reset value and are only read where written.
module complete_binary_tree_check #(
	parameter int MAX_NODES = cbt_pkg::MAX_NODES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [cbt_pkg::S_TDATA_W-1:0] s_tdata,   // left_index[6:0], right_index[13:7]
	input  logic                          s_tlast,   // last_node
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [cbt_pkg::M_TDATA_W-1:0] m_tdata    // is_complete[0], malformed[1]
);
	import cbt_pkg::*;

	cbt_cmd_t cmd;
	cbt_sts_t sts;

	cbt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cbt_dp #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

@@ tb/complete_binary_tree_check_tb.sv @@
module complete_binary_tree_check_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cbt_pkg::*;

	localparam int NODE_LIMIT  = MAX_NODES_DEF;
	localparam int RAND_BEATS  = 1550;
	localparam int CALM_TAIL   = 150;
	localparam int DRAIN_WAIT  = 8 * NODE_LIMIT + 40;
	localparam int LONG_HOLD   = 400;
	localparam int HOLD_AFTER  = 25;

	// Child field codes
	localparam logic [IN_W-1:0] KID_NONE  = CHILD_NONE;
	localparam logic [IN_W-1:0] KID_ZERO  = 7'd0;
	localparam logic [IN_W-1:0] KID_MINUS2 = 7'h7E;
	localparam logic [IN_W-1:0] KID_MOST_NEG = 7'h40;
	localparam logic [IN_W-1:0] KID_MOST_POS = 7'h3F;
	localparam logic [IN_W-1:0] KID_OVER_MAX = 7'd33;

	typedef struct packed {
		logic complete;
		logic malformed;
	} verdict_t;

	localparam verdict_t TREE_OK  = '{complete: 1'b1, malformed: 1'b0};
	localparam verdict_t TREE_BAD = '{complete: 1'b0, malformed: 1'b1};
	localparam verdict_t NO_CALL  = '{complete: 1'b0, malformed: 1'b0};

	typedef struct {
		logic [IN_W-1:0] left_kid;
		logic [IN_W-1:0] right_kid;
		logic            is_last;
		bit              pinned;
		verdict_t        want;
	} node_beat_t;

	typedef enum int {
		SHAPE_FULL,
		SHAPE_RANDOM,
		SHAPE_DAMAGED,
		GRAPH_RANDOM,
		RAW_NOISE,
		SIZE_EDGE
	} tree_kind_t;

	localparam int DIR_N = 22;

	// Directed beats: single nodes, bad indexes, missing root, small shapes, a loop
	node_beat_t directed_tbl [DIR_N] = '{
		'{KID_NONE,     KID_NONE,     1'b1, 1'b1, TREE_OK},
		'{KID_ZERO,     KID_NONE,     1'b1, 1'b1, TREE_BAD},
		'{KID_NONE,     KID_ZERO,     1'b1, 1'b1, TREE_BAD},
		'{7'd2,         KID_NONE,     1'b0, 1'b0, NO_CALL},
		'{7'd1,         KID_NONE,     1'b1, 1'b1, TREE_BAD},
		'{7'd5,         KID_NONE,     1'b1, 1'b1, TREE_BAD},
		'{KID_OVER_MAX, KID_NONE,     1'b1, 1'b1, TREE_BAD},
		'{KID_MOST_NEG, KID_MOST_POS, 1'b1, 1'b1, TREE_BAD},
		'{KID_MINUS2,   KID_NONE,     1'b1, 1'b1, TREE_BAD},
		'{7'd2,         7'd3,         1'b0, 1'b0, NO_CALL},
		'{KID_NONE,     KID_NONE,     1'b0, 1'b0, NO_CALL},
		'{KID_NONE,     KID_NONE,     1'b1, 1'b0, NO_CALL},
		'{KID_NONE,     7'd2,         1'b0, 1'b0, NO_CALL},
		'{KID_NONE,     KID_NONE,     1'b1, 1'b0, NO_CALL},
		'{7'd2,         7'd3,         1'b0, 1'b0, NO_CALL},
		'{7'd2,         7'd3,         1'b0, 1'b0, NO_CALL},
		'{7'd2,         7'd3,         1'b1, 1'b0, NO_CALL},
		'{KID_NONE,     KID_NONE,     1'b0, 1'b0, NO_CALL},
		'{KID_NONE,     KID_NONE,     1'b0, 1'b0, NO_CALL},
		'{7'd1,         7'd2,         1'b1, 1'b0, NO_CALL},
		'{KID_NONE,     KID_NONE,     1'b0, 1'b0, NO_CALL},
		'{KID_NONE,     KID_NONE,     1'b1, 1'b0, NO_CALL}
	};

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 s_tlast  = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	always #10 clk = ~clk;

	complete_binary_tree_check dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Tree state mirrored from the accepted node beats
	logic [5:0]  left_child  [NODE_LIMIT];
	logic [5:0]  right_child [NODE_LIMIT];
	logic        parent_mark [NODE_LIMIT];
	int          nodes_held;
	bit          index_fault;

	verdict_t    verdict_q [$];
	node_beat_t  beat_plan [$];

	int  fails         = 0;
	int  verdicts_seen = 0;
	int  beats_sent    = 0;
	int  trees_done    = 0;
	int  complete_cnt  = 0;
	int  malformed_cnt = 0;
	int  loop_cut_cnt  = 0;
	int  idle_odds     = 0;
	bit  calm          = 1'b0;
	bit  pressure_done = 1'b0;

	// Decode a child field; mark the named node as having a parent
	function automatic logic [5:0] take_child(input logic [IN_W-1:0] raw);
		int v;
		v = $signed(raw);
		if (v == -1)
			return 6'd0;
		if (v < 1 || v > NODE_LIMIT) begin
			index_fault = 1'b1;
			return 6'd0;
		end
		parent_mark[v-1] = 1'b1;
		return v[5:0];
	endfunction

	// Find the root, then walk breadth first and look for a node after a gap
	function automatic verdict_t tree_verdict();
		int        n;
		int        root;
		int        visited;
		bit        found;
		logic [5:0] slot;
		logic [5:0] walk [$];
		verdict_t  vd;
		n = nodes_held;
		root = 0;
		visited = 0;
		found = 1'b0;
		vd = TREE_OK;
		if (index_fault)
			return TREE_BAD;
		for (int i = 0; i < n; i++) begin
			if (left_child[i] > n || right_child[i] > n)
				return TREE_BAD;
			if (!parent_mark[i]) begin
				root = i;
				found = 1'b1;
			end
		end
		if (!found)
			return TREE_BAD;
		walk.push_back(6'(root + 1));
		slot = walk.pop_front();
		while (slot != 0) begin
			// stop a walk that loops back into visited nodes
			if (visited >= n) begin
				loop_cut_cnt++;
				return NO_CALL;
			end
			visited++;
			walk.push_back(left_child[slot-1]);
			walk.push_back(right_child[slot-1]);
			slot = walk.pop_front();
		end
		while (walk.size() > 0) begin
			if (walk.pop_front() != 0) begin
				vd.complete = 1'b0;
				break;
			end
		end
		return vd;
	endfunction

	// Absorb one node beat; return 1 with the verdict on the last node
	function automatic bit take_node(input node_beat_t b, output verdict_t vd);
		logic [5:0] lc;
		logic [5:0] rc;
		lc = take_child(b.left_kid);
		rc = take_child(b.right_kid);
		vd = NO_CALL;
		if (nodes_held < NODE_LIMIT) begin
			left_child[nodes_held]  = lc;
			right_child[nodes_held] = rc;
			nodes_held++;
		end else begin
			index_fault = 1'b1;
		end
		if (!b.is_last)
			return 1'b0;
		vd = tree_verdict();
		trees_done++;
		if (vd.complete)
			complete_cnt++;
		if (vd.malformed)
			malformed_cnt++;
		for (int i = 0; i < NODE_LIMIT; i++)
			parent_mark[i] = 1'b0;
		nodes_held  = 0;
		index_fault = 1'b0;
		return 1'b1;
	endfunction

	// Queue the beats of one tree of the given kind
	task automatic plan_tree(input tree_kind_t kind);
		int         n;
		int         p;
		int         pick;
		int         tmp;
		int         sl    [40];
		int         sr    [40];
		int         perm  [40];
		int         lab_l [40];
		int         lab_r [40];
		int         slots [$];
		node_beat_t b;
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, NODE_LIMIT) : $urandom_range(1, 8);
		if (kind == SIZE_EDGE)
			n = $urandom_range(NODE_LIMIT - 1, NODE_LIMIT + 2);
		for (int k = 0; k < n; k++) begin
			sl[k] = -1;
			sr[k] = -1;
			perm[k] = k + 1;
		end
		// build the shape in breadth-first positions
		if (kind == SHAPE_FULL || kind == SIZE_EDGE) begin
			for (int k = 0; k < n; k++) begin
				if (2 * k + 1 < n)
					sl[k] = 2 * k + 1;
				if (2 * k + 2 < n)
					sr[k] = 2 * k + 2;
			end
		end else begin
			slots = '{0, 1};
			for (int k = 1; k < n; k++) begin
				pick = $urandom_range(0, slots.size() - 1);
				p = slots[pick];
				slots.delete(pick);
				if (p % 2)
					sr[p / 2] = k;
				else
					sl[p / 2] = k;
				slots.push_back(2 * k);
				slots.push_back(2 * k + 1);
			end
		end
		// scatter the positions over random node numbers
		for (int k = n - 1; k > 0; k--) begin
			pick = $urandom_range(0, k);
			tmp = perm[k];
			perm[k] = perm[pick];
			perm[pick] = tmp;
		end
		for (int k = 0; k < n; k++) begin
			lab_l[perm[k]-1] = (sl[k] < 0) ? -1 : perm[sl[k]];
			lab_r[perm[k]-1] = (sr[k] < 0) ? -1 : perm[sr[k]];
		end
		// replace the shape with arbitrary links or raw noise
		if (kind == GRAPH_RANDOM || kind == RAW_NOISE) begin
			for (int i = 0; i < n; i++) begin
				if (kind == RAW_NOISE) begin
					lab_l[i] = $urandom_range(0, 127);
					lab_r[i] = $urandom_range(0, 127);
				end else begin
					tmp = $urandom_range(0, n);
					lab_l[i] = (tmp == 0) ? -1 : tmp;
					tmp = $urandom_range(0, n);
					lab_r[i] = (tmp == 0) ? -1 : tmp;
				end
			end
		end
		// damage one child field
		if (kind == SHAPE_DAMAGED) begin
			pick = $urandom_range(0, n - 1);
			case ($urandom_range(0, 2))
				0: tmp = 0;
				1: tmp = n + 1;
				default: tmp = $urandom_range(0, 127);
			endcase
			if ($urandom_range(0, 1))
				lab_l[pick] = tmp;
			else
				lab_r[pick] = tmp;
		end
		for (int i = 0; i < n; i++) begin
			b.left_kid  = 7'(lab_l[i]);
			b.right_kid = 7'(lab_r[i]);
			b.is_last   = (i == n - 1);
			b.pinned    = 1'b0;
			b.want      = NO_CALL;
			beat_plan.push_back(b);
		end
	endtask

	// Feed node beats
	initial begin : feed
		node_beat_t b;
		verdict_t   vd;
		int         roll;
		tree_kind_t kind;
		for (int i = 0; i < DIR_N; i++)
			beat_plan.push_back(directed_tbl[i]);
		while (beat_plan.size() < DIR_N + RAND_BEATS) begin
			roll = $urandom_range(0, 99);
			if (roll < 45)
				kind = SHAPE_FULL;
			else if (roll < 75)
				kind = SHAPE_RANDOM;
			else if (roll < 85)
				kind = SHAPE_DAMAGED;
			else if (roll < 92)
				kind = GRAPH_RANDOM;
			else if (roll < 96)
				kind = RAW_NOISE;
			else
				kind = SIZE_EDGE;
			plan_tree(kind);
		end
		nodes_held  = 0;
		index_fault = 1'b0;
		for (int i = 0; i < NODE_LIMIT; i++)
			parent_mark[i] = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		while (beat_plan.size() > 0) begin
			b = beat_plan.pop_front();
			// insert an idle burst now and then
			if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= {2'b00, b.right_kid, b.left_kid};
			s_tlast  <= b.is_last;
			do
				@(posedge clk);
			while (!s_tready);
			beats_sent++;
			if (take_node(b, vd))
				verdict_q.push_back(b.pinned ? b.want : vd);
			if (beats_sent % 256 == 0)
				case ($urandom_range(0, 2))
					0: idle_odds = 0;
					1: idle_odds = 3;
					default: idle_odds = 10;
				endcase
			calm = (beat_plan.size() < CALM_TAIL);
		end
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;

		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Sent %0d node beats in %0d trees; %0d verdicts checked.",
			beats_sent, trees_done, verdicts_seen);
		$display("Trees: %0d complete, %0d malformed, %0d walks cut short by a loop.",
			complete_cnt, malformed_cnt, loop_cut_cnt);
		if (fails == 0 && verdict_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Take verdict beats, check them, and drive the ready side
	initial begin : collect
		verdict_t got;
		verdict_t want;
		int       hold;
		hold = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.complete  = m_tdata[0];
				got.malformed = m_tdata[1];
				verdicts_seen++;
				if (verdict_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("verdict %0d arrived with none expected:",
							verdicts_seen, " complete=%0b malformed=%0b",
							got.complete, got.malformed);
				end else begin
					want = verdict_q.pop_front();
					if (got != want) begin
						fails++;
						if (fails <= 10)
							$display("verdict %0d: expected complete=%0b malformed=%0b,",
								verdicts_seen, want.complete, want.malformed,
								" got complete=%0b malformed=%0b",
								got.complete, got.malformed);
					end
				end
			end
			// hold off long once so the block backs up into its input
			if (verdicts_seen == HOLD_AFTER && !pressure_done) begin
				pressure_done = 1'b1;
				hold = LONG_HOLD;
				m_tready <= 1'b0;
			end else if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
				hold = $urandom_range(0, 14);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Stop a hung run
	initial begin : watchdog
		#40_000_000;
		$display("Timeout with %0d verdicts outstanding", verdict_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ files.f @@
sv/cbt_pkg.sv
sv/cbt_ram.sv
sv/cbt_ctrl.sv
sv/cbt_dp.sv
sv/complete_binary_tree_check.sv
tb/complete_binary_tree_check_tb.sv
